FILE: src/sysex_seven_bit_codec_assert.svh
// assertion macros for the sysex seven bit codec
`ifndef SYSEX_SEVEN_BIT_CODEC_ASSERT_SVH
`define SYSEX_SEVEN_BIT_CODEC_ASSERT_SVH

// condition must hold in the same cycle
`define SYSEX7_ASSERT_NOW(label, clk, rst_n, cond, expect_now, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> (expect_now)) else $error(msg);

// condition must hold in the next cycle
`define SYSEX7_ASSERT_NEXT(label, clk, rst_n, cond, expect_next, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (expect_next)) else $error(msg);

`endif

FILE: src/sysex7_pkg.sv
// shared types and constants for the sysex seven bit codec
`default_nettype none

package sysex7_pkg;

    // group geometry
    localparam int GROUP_SIZE = 7;
    localparam logic [6:0] LOW_SEVEN = 7'h7F;
    localparam int QUEUE_DEPTH = 2;

    // mode register codes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } result_t;

    // work classes handed from front to back
    typedef enum logic [1:0] {
        CMD_ENC_STORE,
        CMD_ENC_FLUSH,
        CMD_DEC_HEADER,
        CMD_DEC_DATA
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] data;
        logic [2:0] slot;
        logic       last;
    } cmd_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_HEADER,
        BK_DATA
    } back_state_t;

    // back end status toward the top level
    typedef struct packed {
        logic busy;
        logic cmd_pop;
    } back_stat_t;

endpackage

`default_nettype wire

FILE: src/sysex7_queue.sv
// command queue between the front and back ends
`default_nettype none

module sysex7_queue #(
    parameter int DEPTH = sysex7_pkg::QUEUE_DEPTH
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 wr_en,
    input  sysex7_pkg::cmd_t    wr_cmd,
    output logic                full,
    input  wire                 rd_en,
    output sysex7_pkg::cmd_t    rd_cmd,
    output logic                empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    sysex7_pkg::cmd_t entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full  = (count_reg == FULL_COUNT);
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_cmd = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: src/sysex7_front.sv
// front end: takes input beats, tracks group progress, classifies work
`default_nettype none

module sysex7_front (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_we,
    input  wire                   cfg_data,
    input  wire                   push,
    input  sysex7_pkg::in_item_t  item,
    input  wire                   q_full,
    output logic                  cmd_push,
    output sysex7_pkg::cmd_t      cmd
);

    localparam logic [2:0] LAST_SLOT = 3'(sysex7_pkg::GROUP_SIZE - 1);
    localparam logic [2:0] LAST_POS  = 3'(sysex7_pkg::GROUP_SIZE);

    logic       mode_reg;
    logic [2:0] fill_reg, fill_next;
    logic [2:0] pos_reg, pos_next;

    assign cmd_push = push && !q_full;

    // classify the incoming beat
    always_comb
    begin
        cmd.data  = item.data_byte;
        cmd.last  = item.last_byte;
        cmd.slot  = '0;
        cmd.op    = sysex7_pkg::CMD_ENC_STORE;
        fill_next = fill_reg;
        pos_next  = pos_reg;
        if (mode_reg == sysex7_pkg::MODE_ENCODE)
        begin
            cmd.slot = fill_reg;
            if (fill_reg == LAST_SLOT || item.last_byte)
            begin
                cmd.op    = sysex7_pkg::CMD_ENC_FLUSH;
                fill_next = '0;
            end
            else
            begin
                cmd.op    = sysex7_pkg::CMD_ENC_STORE;
                fill_next = fill_reg + 1'b1;
            end
        end
        else if (pos_reg == '0)
        begin
            cmd.op   = sysex7_pkg::CMD_DEC_HEADER;
            pos_next = item.last_byte ? 3'd0 : 3'd1;
        end
        else
        begin
            cmd.op   = sysex7_pkg::CMD_DEC_DATA;
            cmd.slot = pos_reg - 1'b1;
            pos_next = (item.last_byte || pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
        end
    end

    // mode register and group counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= sysex7_pkg::MODE_ENCODE;
            fill_reg <= '0;
            pos_reg  <= '0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_data;
            fill_reg <= '0;
            pos_reg  <= '0;
        end
        else if (cmd_push)
        begin
            fill_reg <= fill_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/sysex7_back.sv
// back end: holds the chunk, emits header and data beats through an output register
`default_nettype none

module sysex7_back (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    clear,
    input  sysex7_pkg::cmd_t       cmd,
    input  wire                    q_empty,
    input  wire                    pop,
    output logic                   empty,
    output sysex7_pkg::result_t    result,
    output sysex7_pkg::back_stat_t stat
);

    sysex7_pkg::back_state_t state_reg, state_next;

    logic [7:0] buf_reg [sysex7_pkg::GROUP_SIZE];
    logic       buf_we;
    logic [2:0] cnt_reg, cnt_next;
    logic [2:0] idx_reg, idx_next;
    logic       last_reg, last_next;
    logic [6:0] hdr_reg, hdr_next;
    logic       out_valid_reg, out_valid_next;
    sysex7_pkg::result_t out_reg, out_next;
    logic       load_ok;
    logic       q_pop;
    logic [6:0] chunk_hdr;

    assign empty   = !out_valid_reg;
    assign result  = out_reg;
    assign load_ok = !out_valid_reg || pop;
    assign stat.busy    = (state_reg != sysex7_pkg::BK_IDLE);
    assign stat.cmd_pop = q_pop;

    // header bits from the held chunk
    always_comb
    begin
        for (int i = 0; i < sysex7_pkg::GROUP_SIZE; i++)
        begin
            chunk_hdr[i] = buf_reg[i][7] && (3'(i) <= cnt_reg);
        end
    end

    // sequencer next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        hdr_next       = hdr_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        buf_we         = 1'b0;
        q_pop          = 1'b0;
        unique case (state_reg)
            sysex7_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (cmd.op)
                        sysex7_pkg::CMD_ENC_STORE:
                        begin
                            buf_we = 1'b1;
                            q_pop  = 1'b1;
                        end
                        sysex7_pkg::CMD_ENC_FLUSH:
                        begin
                            buf_we     = 1'b1;
                            q_pop      = 1'b1;
                            cnt_next   = cmd.slot;
                            last_next  = cmd.last;
                            state_next = sysex7_pkg::BK_HEADER;
                        end
                        sysex7_pkg::CMD_DEC_HEADER:
                        begin
                            q_pop    = 1'b1;
                            hdr_next = cmd.data[6:0] & sysex7_pkg::LOW_SEVEN;
                        end
                        sysex7_pkg::CMD_DEC_DATA:
                        begin
                            if (load_ok)
                            begin
                                q_pop             = 1'b1;
                                out_valid_next    = 1'b1;
                                out_next.out_byte = {cmd.data[7] | hdr_reg[cmd.slot],
                                                     cmd.data[6:0]};
                                out_next.out_last = cmd.last;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            sysex7_pkg::BK_HEADER:
            begin
                if (load_ok)
                begin
                    out_valid_next    = 1'b1;
                    out_next.out_byte = {1'b0, chunk_hdr};
                    out_next.out_last = 1'b0;
                    idx_next          = '0;
                    state_next        = sysex7_pkg::BK_DATA;
                end
            end
            sysex7_pkg::BK_DATA:
            begin
                if (load_ok)
                begin
                    out_valid_next    = 1'b1;
                    out_next.out_byte = {1'b0, buf_reg[idx_reg][6:0] & sysex7_pkg::LOW_SEVEN};
                    out_next.out_last = last_reg && (idx_reg == cnt_reg);
                    if (idx_reg == cnt_reg)
                    begin
                        state_next = sysex7_pkg::BK_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = sysex7_pkg::BK_IDLE;
            end
        endcase
        if (clear)
        begin
            hdr_next = '0;
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sysex7_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            hdr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            hdr_reg       <= hdr_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

    // chunk buffer
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_reg[cmd.slot] <= cmd.data;
        end
    end

endmodule

`default_nettype wire

FILE: src/sysex_seven_bit_codec.sv
// top level of the sysex seven bit codec
// Byte stream codec for MIDI SysEx 7-bit packing; cfg_data 0 encodes, 1 decodes, and a
// write drops any partial group. Input beats enter a command queue of QUEUE_DEPTH entries
// and are taken at one per cycle while it has room. Decode gives one result beat per data
// beat, one per cycle while the output register is free or being popped, with header beats
// producing nothing. Encode stores one beat per cycle into the chunk buffer while the back
// end is idle and, on the seventh beat or a last beat, sends a header and up to seven data
// beats through the single output register at one per cycle while it is free or popped.
// The back end takes no command while it emits a chunk.
`default_nettype none

module sysex_seven_bit_codec #(
    parameter int QUEUE_DEPTH = sysex7_pkg::QUEUE_DEPTH
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_we,
    input  wire                   cfg_data,
    input  wire                   push,
    output logic                  full,
    input  sysex7_pkg::in_item_t  item,
    output logic                  empty,
    input  wire                   pop,
    output sysex7_pkg::result_t   result
);

    `include "sysex_seven_bit_codec_assert.svh"

    logic                   cmd_push;
    sysex7_pkg::cmd_t       front_cmd;
    sysex7_pkg::cmd_t       queue_cmd;
    logic                   q_full;
    logic                   q_empty;
    sysex7_pkg::back_stat_t back_stat;

    assign full = q_full;

    // classify input beats
    sysex7_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .push     (push),
        .item     (item),
        .q_full   (q_full),
        .cmd_push (cmd_push),
        .cmd      (front_cmd)
    );

    // decouple front and back
    sysex7_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_cmd (front_cmd),
        .full   (q_full),
        .rd_en  (back_stat.cmd_pop),
        .rd_cmd (queue_cmd),
        .empty  (q_empty)
    );

    // carry out the work and emit result beats
    sysex7_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (cfg_we),
        .cmd     (queue_cmd),
        .q_empty (q_empty),
        .pop     (pop),
        .empty   (empty),
        .result  (result),
        .stat    (back_stat)
    );

    // consistency checks
    `SYSEX7_ASSERT_NOW(a_no_pop_when_busy, clk, rst_n, back_stat.busy, !back_stat.cmd_pop,
        "back end took a command while emitting a chunk")
    `SYSEX7_ASSERT_NOW(a_no_pop_from_empty, clk, rst_n, q_empty, !back_stat.cmd_pop,
        "back end popped an empty queue")
    `SYSEX7_ASSERT_NEXT(a_accepted_beat_queued, clk, rst_n, cmd_push, !q_empty,
        "accepted beat did not reach the queue")

endmodule

`default_nettype wire
